### hdl/fcfl_pkg.sv
`default_nettype none

package fcfl_pkg;

    // Pool geometry
    localparam int NUM_CHUNKS = 256;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int LINK_W     = $clog2(NUM_CHUNKS + 1);
    localparam int CNT_W      = $clog2(NUM_CHUNKS + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_CHUNKS);

    // Field widths
    localparam int FIELD_IDX_W = 8;
    localparam int CHUNK_W     = 17;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int USE_W       = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RST = CHUNK_W'(64);
    localparam logic [CHUNK_W-1:0] CHUNK_BYTES_MIN = CHUNK_W'(8);
    localparam logic [ADDR_W-1:0]  BASE_ADDR_RST   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_BYTES = 1'b0,
        CFG_BASE_ADDR   = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_func                  func;
        logic [FIELD_IDX_W-1:0] rel_idx;
        logic                   is_null;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [FIELD_IDX_W-1:0] granted_index;
        logic [ADDR_W-1:0]      granted_address;
        logic [USE_W-1:0]       in_use_count;
    } t_rsp;

    // Link store access from the controller
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

### hdl/fcfl_link_ram.sv
`default_nettype none

module fcfl_link_ram (
    input  wire logic                       i_clk,
    input  wire fcfl_pkg::t_ram_req         i_ram,
    output logic [fcfl_pkg::LINK_W-1:0]     o_rdata
);
    import fcfl_pkg::*;

    // One link per chunk: next free chunk or the null mark
    logic [LINK_W-1:0] r_mem [NUM_CHUNKS];
    logic [LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ram.we) begin
            r_mem[i_ram.waddr] <= i_ram.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ram.re) begin
            r_rdata <= r_mem[i_ram.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/fcfl_core.sv
`default_nettype none

module fcfl_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [fcfl_pkg::CHUNK_W-1:0] i_chunk_size,
    input  wire logic [fcfl_pkg::ADDR_W-1:0]  i_base_addr,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire fcfl_pkg::t_req              i_req,
    output logic                             o_rsp_valid,
    input  wire logic                        i_rsp_ready,
    output fcfl_pkg::t_rsp                   o_rsp,
    output fcfl_pkg::t_ram_req               o_ram,
    input  wire logic [fcfl_pkg::LINK_W-1:0]  i_ram_rdata
);
    import fcfl_pkg::*;

    localparam int PROD_W = IDX_W + CHUNK_W;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_init_idx, n_init_idx;
    logic [LINK_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_got, n_got;
    t_rsp              r_res, n_res;
    t_rsp              r_rsp, n_rsp;
    logic              r_rsp_valid, n_rsp_valid;

    logic              w_fire;
    logic              w_out_free;
    logic              w_head_null;
    logic              w_rel_bad;
    logic              w_init_last;
    logic [PROD_W-1:0] w_prod;
    t_rsp              w_alloc_rsp;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_fire      = i_req_valid && o_req_ready;
    assign w_out_free  = !r_rsp_valid || i_rsp_ready;
    assign w_head_null = (r_head >= LINK_NULL);
    assign w_rel_bad   = i_req.is_null ||
                         (LINK_W'(i_req.rel_idx) >= LINK_W'(NUM_CHUNKS));
    assign w_init_last = (r_init_idx == LINK_W'(NUM_CHUNKS - 1));

    // Granted chunk address: base plus index times size
    assign w_prod = PROD_W'(r_got) * PROD_W'(i_chunk_size);

    always_comb begin
        w_alloc_rsp.status          = ST_DONE;
        w_alloc_rsp.granted_index   = FIELD_IDX_W'(r_got);
        w_alloc_rsp.granted_address = i_base_addr + ADDR_W'(w_prod);
        w_alloc_rsp.in_use_count    = USE_W'(r_count);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (w_init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_fire) begin
                    if (i_req.func == FUNC_ALLOC && !w_head_null) n_state = S_READ;
                    else n_state = S_HOLD;
                end
            end
            S_READ: begin
                n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Link store port: init sweep, pop read, push write
    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.waddr = IDX_W'(r_init_idx);
        o_ram.wdata = r_init_idx + LINK_W'(1);
        o_ram.re    = 1'b0;
        o_ram.raddr = IDX_W'(r_head);
        case (r_state)
            S_INIT: begin
                o_ram.we = 1'b1;
            end
            S_IDLE: begin
                if (w_fire && i_req.func == FUNC_ALLOC) begin
                    o_ram.re = 1'b1;
                end
                if (w_fire && i_req.func == FUNC_RELEASE && !w_rel_bad) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = IDX_W'(i_req.rel_idx);
                    o_ram.wdata = r_head;
                end
            end
            default: begin
            end
        endcase
    end

    // Head, count and result datapath
    always_comb begin
        n_init_idx  = r_init_idx;
        n_head      = r_head;
        n_count     = r_count;
        n_got       = r_got;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            S_INIT: begin
                n_init_idx = r_init_idx + LINK_W'(1);
            end
            S_IDLE: begin
                if (w_fire) begin
                    n_res.granted_index   = '0;
                    n_res.granted_address = '0;
                    if (i_req.func == FUNC_ALLOC) begin
                        n_res.status       = ST_EMPTY;
                        n_res.in_use_count = USE_W'(r_count);
                        if (!w_head_null) begin
                            n_got = IDX_W'(r_head);
                            if (r_count < CNT_W'(NUM_CHUNKS)) n_count = r_count + CNT_W'(1);
                        end
                    end else if (w_rel_bad) begin
                        n_res.status       = ST_IGNORED;
                        n_res.in_use_count = USE_W'(r_count);
                    end else begin
                        n_head = LINK_W'(i_req.rel_idx);
                        if (r_count != '0) n_count = r_count - CNT_W'(1);
                        n_res.status       = ST_DONE;
                        n_res.in_use_count = USE_W'(n_count);
                    end
                end
            end
            S_READ: begin
                // popped head's link arrives from the store
                n_head = i_ram_rdata;
                if (w_out_free) begin
                    n_rsp       = w_alloc_rsp;
                    n_rsp_valid = 1'b1;
                end else begin
                    n_res = w_alloc_rsp;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_got <= n_got;
        r_res <= n_res;
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

### hdl/fixed_chunk_free_list_allocator.sv
// Channel    Direction  Handshake                  Payload
// request    in         i_req_valid / o_req_ready  i_req  (func, rel_idx, is_null)
// response   out        o_rsp_valid / i_rsp_ready  o_rsp  (status, index, address, count)
// config     in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// An allocate reads the head's link from the registered link store before the head
// can move on. After reset an init sweep writes the 256 links, one per cycle; no
// request is taken until the sweep is done. Configuration writes are taken at any
// time.
// A result waiting in the output register does not block the next request;
// the block holds in its own state until the output register frees up.
`default_nettype none

module fixed_chunk_free_list_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire fcfl_pkg::t_req                 i_req,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output fcfl_pkg::t_rsp                      o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fcfl_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fcfl_pkg::*;

    logic [CHUNK_W-1:0] r_chunk_bytes;
    logic [ADDR_W-1:0]  r_base_addr;
    logic [CHUNK_W-1:0] w_chunk_size;
    t_ram_req           w_ram;
    logic [LINK_W-1:0]  w_ram_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes <= CHUNK_BYTES_RST;
            r_base_addr   <= BASE_ADDR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_CHUNK_BYTES: r_chunk_bytes <= i_cfg_wdata[CHUNK_W-1:0];
                CFG_BASE_ADDR:   r_base_addr   <= i_cfg_wdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sizes below the minimum count as the minimum
    assign w_chunk_size = (r_chunk_bytes < CHUNK_BYTES_MIN) ? CHUNK_BYTES_MIN : r_chunk_bytes;

    fcfl_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chunk_size (w_chunk_size),
        .i_base_addr  (r_base_addr),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_rsp        (o_rsp),
        .o_ram        (w_ram),
        .i_ram_rdata  (w_ram_rdata)
    );

    fcfl_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_ram   (w_ram),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire

### hdl/fcfl_checker.sv
`default_nettype none

module fcfl_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           o_req_ready,
    input  wire logic           o_rsp_valid,
    input  wire logic           i_rsp_ready,
    input  wire fcfl_pkg::t_rsp o_rsp
);
    import fcfl_pkg::*;

    // A pending response holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    // One request at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in flight");

    // Only a completed allocate carries index and address
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_DONE |->
            o_rsp.granted_index == '0 && o_rsp.granted_address == '0)
        else $error("grant fields set on a failed request");

    // In-use count never exceeds the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.in_use_count <= USE_W'(NUM_CHUNKS))
        else $error("in-use count beyond pool size");

endmodule

bind fixed_chunk_free_list_allocator fcfl_checker u_fcfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

`default_nettype wire
